// ----- hdl/lsc_pkg.sv -----
package lsc_pkg;

    localparam int C_SLOTS      = 4;
    localparam int C_KEY_BITS   = 8;
    localparam int C_STAMP_BITS = 32;
    localparam int C_SLOT_BITS  = 2;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_TOUCH   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    typedef struct packed {
        logic [1:0]            operation;
        logic [C_KEY_BITS-1:0] key;
    } t_req;

    typedef struct packed {
        logic [C_SLOT_BITS-1:0] slot_index;
        logic                   hit;
        logic                   evicted;
        logic [C_KEY_BITS-1:0]  evicted_key;
    } t_rsp;

    typedef struct packed {
        logic valid;
        logic found;
        logic free_found;
        logic have_min;
    } t_scan_flags;

    typedef struct packed {
        logic en;
        logic clear_all;
        logic clear_stamps;
        logic free;
        logic write;
        logic touch;
    } t_upd_ctl;

endpackage

// ----- hdl/lsc_cell.sv -----
module lsc_cell
    import lsc_pkg::*;
#(
    parameter int SLOTS      = C_SLOTS,
    parameter int STAMP_BITS = C_STAMP_BITS,
    parameter int INDEX      = 0,
    localparam int SW        = $clog2(SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [C_KEY_BITS-1:0] i_key,
    input  t_scan_flags           i_flags,
    input  logic [SW-1:0]         i_found_idx,
    input  logic [SW-1:0]         i_free_idx,
    input  logic [SW-1:0]         i_min_idx,
    input  logic [STAMP_BITS-1:0] i_min_stamp,
    input  logic [C_KEY_BITS-1:0] i_min_key,
    output t_scan_flags           o_flags,
    output logic [SW-1:0]         o_found_idx,
    output logic [SW-1:0]         o_free_idx,
    output logic [SW-1:0]         o_min_idx,
    output logic [STAMP_BITS-1:0] o_min_stamp,
    output logic [C_KEY_BITS-1:0] o_min_key,
    input  t_upd_ctl              i_upd,
    input  logic [SW-1:0]         i_upd_idx,
    input  logic [C_KEY_BITS-1:0] i_upd_key,
    input  logic [STAMP_BITS-1:0] i_upd_stamp
);

    localparam logic [SW-1:0] MY_IDX = SW'(INDEX);

    logic [C_KEY_BITS-1:0] r_key;
    logic                  r_valid;
    logic [STAMP_BITS-1:0] r_stamp;

    t_scan_flags           r_flags;
    t_scan_flags           n_flags;
    logic [SW-1:0]         r_found_idx, n_found_idx;
    logic [SW-1:0]         r_free_idx, n_free_idx;
    logic [SW-1:0]         r_min_idx, n_min_idx;
    logic [STAMP_BITS-1:0] r_min_stamp, n_min_stamp;
    logic [C_KEY_BITS-1:0] r_min_key, n_min_key;

    logic match;
    logic take_min;
    logic selected;

    assign match    = r_valid && (r_key == i_key);
    assign take_min = !i_flags.have_min || (r_stamp < i_min_stamp);
    assign selected = (i_upd_idx == MY_IDX);

    always_comb begin
        n_flags.valid      = i_flags.valid;
        n_flags.found      = i_flags.found || match;
        n_flags.free_found = i_flags.free_found || !r_valid;
        n_flags.have_min   = 1'b1;
        n_found_idx        = i_flags.found ? i_found_idx : MY_IDX;
        n_free_idx         = i_flags.free_found ? i_free_idx : MY_IDX;
        n_min_idx          = take_min ? MY_IDX : i_min_idx;
        n_min_stamp        = take_min ? r_stamp : i_min_stamp;
        n_min_key          = take_min ? r_key : i_min_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
        r_found_idx <= n_found_idx;
        r_free_idx  <= n_free_idx;
        r_min_idx   <= n_min_idx;
        r_min_stamp <= n_min_stamp;
        r_min_key   <= n_min_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_valid <= 1'b0;
            r_stamp <= '0;
        end else if (i_upd.en) begin
            if (i_upd.clear_all) begin
                r_key   <= '0;
                r_valid <= 1'b0;
                r_stamp <= '0;
            end else begin
                if (i_upd.clear_stamps) begin
                    r_stamp <= '0;
                end
                if (selected && i_upd.free) begin
                    r_key   <= '0;
                    r_valid <= 1'b0;
                    r_stamp <= '0;
                end
                if (selected && i_upd.write) begin
                    r_key   <= i_upd_key;
                    r_valid <= 1'b1;
                end
                if (selected && i_upd.touch) begin
                    r_stamp <= i_upd_stamp;
                end
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_found_idx = r_found_idx;
    assign o_free_idx  = r_free_idx;
    assign o_min_idx   = r_min_idx;
    assign o_min_stamp = r_min_stamp;
    assign o_min_key   = r_min_key;

endmodule

// ----- hdl/lru_slot_cache.sv -----
// Fully associative cache of SLOTS entries with least-recently-used
// replacement by stamp. Present a word on i_req with start high while busy
// is low; the result appears on o_rsp for exactly one cycle with o_done high,
// and it cannot be held off, so capture it in that cycle. Busy stays high
// from acceptance until the result, and drops together with o_done, so a new
// word is taken only once the last one is through. Each word passes through a
// lookup that walks the row of slot cells one cell per cycle, and then the
// decision is written back to the cells as the result is registered.
module lru_slot_cache
    import lsc_pkg::*;
#(
    parameter int SLOTS      = C_SLOTS,
    parameter int STAMP_BITS = C_STAMP_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int SW = $clog2(SLOTS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  r_state;
    logic                  r_launch;
    logic [1:0]            r_op;
    logic [C_KEY_BITS-1:0] r_key;
    logic [STAMP_BITS-1:0] r_counter, n_counter;
    logic                  r_done;
    t_rsp                  r_rsp, n_rsp;

    t_upd_ctl              upd;
    logic [SW-1:0]         upd_idx;
    logic [STAMP_BITS-1:0] upd_stamp;
    logic [STAMP_BITS-1:0] inc_counter;
    logic [SW+1:0]         wide_idx;
    logic                  accept;

    t_scan_flags           c_flags     [SLOTS+1];
    logic [SW-1:0]         c_found_idx [SLOTS+1];
    logic [SW-1:0]         c_free_idx  [SLOTS+1];
    logic [SW-1:0]         c_min_idx   [SLOTS+1];
    logic [STAMP_BITS-1:0] c_min_stamp [SLOTS+1];
    logic [C_KEY_BITS-1:0] c_min_key   [SLOTS+1];

    t_scan_flags           last;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign c_flags[0]     = '{valid: r_launch, found: 1'b0, free_found: 1'b0, have_min: 1'b0};
    assign c_found_idx[0] = '0;
    assign c_free_idx[0]  = '0;
    assign c_min_idx[0]   = '0;
    assign c_min_stamp[0] = '0;
    assign c_min_key[0]   = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lsc_cell #(
            .SLOTS      (SLOTS),
            .STAMP_BITS (STAMP_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_flags     (c_flags[g]),
            .i_found_idx (c_found_idx[g]),
            .i_free_idx  (c_free_idx[g]),
            .i_min_idx   (c_min_idx[g]),
            .i_min_stamp (c_min_stamp[g]),
            .i_min_key   (c_min_key[g]),
            .o_flags     (c_flags[g+1]),
            .o_found_idx (c_found_idx[g+1]),
            .o_free_idx  (c_free_idx[g+1]),
            .o_min_idx   (c_min_idx[g+1]),
            .o_min_stamp (c_min_stamp[g+1]),
            .o_min_key   (c_min_key[g+1]),
            .i_upd       (upd),
            .i_upd_idx   (upd_idx),
            .i_upd_key   (r_key),
            .i_upd_stamp (upd_stamp)
        );
    end

    assign last        = c_flags[SLOTS];
    assign inc_counter = r_counter + STAMP_BITS'(1);

    always_comb begin
        upd       = '0;
        upd_idx   = '0;
        upd_stamp = (inc_counter == '0) ? STAMP_BITS'(1) : inc_counter;
        n_counter = r_counter;
        n_rsp     = '0;
        wide_idx  = '0;
        if (r_state == S_SCAN && last.valid) begin
            upd.en = 1'b1;
            if (r_op == OP_CLEAR) begin
                upd.clear_all = 1'b1;
                n_counter     = '0;
            end else if (last.found) begin
                upd_idx   = c_found_idx[SLOTS];
                n_rsp.hit = 1'b1;
                if (r_op == OP_RELEASE) begin
                    upd.free = 1'b1;
                end else begin
                    upd.touch = 1'b1;
                end
            end else if (r_op == OP_ACQUIRE) begin
                upd.write = 1'b1;
                upd.touch = 1'b1;
                if (last.free_found) begin
                    upd_idx = c_free_idx[SLOTS];
                end else begin
                    upd_idx           = c_min_idx[SLOTS];
                    n_rsp.evicted     = 1'b1;
                    n_rsp.evicted_key = c_min_key[SLOTS];
                end
            end
            if (upd.touch) begin
                n_counter        = upd_stamp;
                upd.clear_stamps = (inc_counter == '0);
            end
            if (upd.touch || upd.free) begin
                wide_idx = {2'b00, upd_idx};
            end
            n_rsp.slot_index = wide_idx[C_SLOT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_done    <= 1'b0;
            r_counter <= '0;
        end else begin
            r_launch  <= accept;
            r_done    <= upd.en;
            r_counter <= n_counter;
            if (accept) begin
                r_state <= S_SCAN;
            end else if (upd.en) begin
                r_state <= S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.operation;
            r_key <= i_req.key;
        end
        if (upd.en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_last_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last.valid |-> r_state == S_SCAN)
        else $error("scan token left the row outside a scan");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !busy)
        else $error("result strobe while still busy");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_rsp.evicted |-> !r_rsp.hit)
        else $error("eviction reported on a hit");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_SCAN && r_launch)
        else $error("accepted word did not launch a scan");

    a_counter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd.en && upd.touch |=> r_counter != '0)
        else $error("use counter zero after a touch");

endmodule

// ----- test/lru_slot_cache_test.sv -----
`timescale 1ns / 100ps

module lru_slot_cache_test;
    import lsc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_done;
    t_rsp o_rsp;

    lru_slot_cache uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [C_KEY_BITS-1:0]   slot_key   [C_SLOTS];
    logic                    slot_valid [C_SLOTS];
    logic [C_STAMP_BITS-1:0] slot_stamp [C_SLOTS];
    logic [C_STAMP_BITS-1:0] use_count;

    t_req req_pending [$];
    t_rsp rsp_expected [$];

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_hits = 0;
    int n_evictions = 0;
    int n_clears = 0;

    function automatic void clear_cache();
        for (int i = 0; i < C_SLOTS; i++) begin
            slot_key[i] = '0;
            slot_valid[i] = 1'b0;
            slot_stamp[i] = '0;
        end
        use_count = '0;
    endfunction

    function automatic void free_slot(int s);
        slot_key[s] = '0;
        slot_valid[s] = 1'b0;
        slot_stamp[s] = '0;
    endfunction

    function automatic void stamp_slot(int s);
        use_count = use_count + 1'b1;
        if (use_count == '0) begin
            use_count = C_STAMP_BITS'(1);
            for (int i = 0; i < C_SLOTS; i++) begin
                slot_stamp[i] = '0;
            end
        end
        slot_stamp[s] = use_count;
    endfunction

    function automatic t_rsp cache_step(t_req w);
        t_rsp r;
        int s;
        r = '0;
        s = -1;
        if (w.operation == OP_CLEAR) begin
            clear_cache();
            n_clears++;
        end else begin
            for (int i = 0; i < C_SLOTS; i++) begin
                if (s < 0 && slot_valid[i] && slot_key[i] == w.key) begin
                    s = i;
                end
            end
            if (s >= 0) begin
                r.hit = 1'b1;
                r.slot_index = s[C_SLOT_BITS-1:0];
                n_hits++;
                if (w.operation == OP_RELEASE) begin
                    free_slot(s);
                end else begin
                    stamp_slot(s);
                end
            end else if (w.operation == OP_ACQUIRE) begin
                for (int i = 0; i < C_SLOTS; i++) begin
                    if (s < 0 && !slot_valid[i]) begin
                        s = i;
                    end
                end
                if (s < 0) begin
                    s = 0;
                    for (int i = 1; i < C_SLOTS; i++) begin
                        if (slot_stamp[i] < slot_stamp[s]) begin
                            s = i;
                        end
                    end
                    r.evicted = 1'b1;
                    r.evicted_key = slot_key[s];
                    n_evictions++;
                    free_slot(s);
                end
                slot_key[s] = w.key;
                slot_valid[s] = 1'b1;
                stamp_slot(s);
                r.slot_index = s[C_SLOT_BITS-1:0];
            end
        end
        return r;
    endfunction

    function automatic void add_word(logic [1:0] op, logic [C_KEY_BITS-1:0] key);
        t_req w;
        w.operation = op;
        w.key = key;
        req_pending.push_back(w);
    endfunction

    // drive: hold a word until taken, then pick the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                rsp_expected.push_back(cache_step(i_req));
                n_sent++;
            end
            if (!start || !busy) begin
                if (req_pending.size() > 0 &&
                    ((n_sent >= 600 && n_sent < 900) || $urandom_range(99) >= 35)) begin
                    start <= 1'b1;
                    i_req <= req_pending.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (rsp_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_rsp);
                n_errors++;
            end else begin
                t_rsp exp_rsp;
                exp_rsp = rsp_expected.pop_front();
                n_checked++;
                if (o_rsp.slot_index !== exp_rsp.slot_index || o_rsp.hit !== exp_rsp.hit ||
                    o_rsp.evicted !== exp_rsp.evicted ||
                    o_rsp.evicted_key !== exp_rsp.evicted_key) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, exp_rsp, o_rsp);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        logic [C_KEY_BITS-1:0] pool [8];
        int psize;
        int roll;
        logic [C_KEY_BITS-1:0] key;
        clear_cache();

        add_word(OP_ACQUIRE, 8'h00);
        add_word(OP_ACQUIRE, 8'hFF);
        add_word(OP_ACQUIRE, 8'h00);
        add_word(OP_ACQUIRE, 8'h55);
        add_word(OP_ACQUIRE, 8'hAA);
        add_word(OP_ACQUIRE, 8'h01);
        add_word(OP_TOUCH, 8'h55);
        add_word(OP_TOUCH, 8'h07);
        add_word(OP_RELEASE, 8'hAA);
        add_word(OP_RELEASE, 8'h07);
        add_word(OP_ACQUIRE, 8'h80);
        add_word(OP_ACQUIRE, 8'h7F);
        add_word(OP_ACQUIRE, 8'h01);
        add_word(OP_ACQUIRE, 8'hFE);
        add_word(OP_CLEAR, 8'hFF);
        add_word(OP_TOUCH, 8'h55);
        add_word(OP_RELEASE, 8'h80);
        add_word(OP_ACQUIRE, 8'h80);
        add_word(OP_RELEASE, 8'h80);
        add_word(OP_ACQUIRE, 8'h80);
        add_word(OP_CLEAR, 8'h00);

        // small key pools keep the cache full, so hits and evictions are common
        for (int b = 0; b < 28; b++) begin
            psize = $urandom_range(7, 5);
            for (int i = 0; i < 8; i++) begin
                pool[i] = C_KEY_BITS'($urandom_range(255));
            end
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(7) == 0) begin
                    key = C_KEY_BITS'($urandom_range(255));
                end else begin
                    key = pool[3'($urandom_range(psize - 1))];
                end
                roll = $urandom_range(99);
                if (roll < 50) begin
                    add_word(OP_ACQUIRE, key);
                end else if (roll < 72) begin
                    add_word(OP_TOUCH, key);
                end else if (roll < 97) begin
                    add_word(OP_RELEASE, key);
                end else begin
                    add_word(OP_CLEAR, key);
                end
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_pending.size() > 0 || start || rsp_expected.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (C_SLOTS + 4) @(negedge i_clk);

        $display("%0d words sent, %0d results checked, %0d errors", n_sent, n_checked, n_errors);
        $display("%0d hits, %0d evictions, %0d full clears", n_hits, n_evictions, n_clears);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("timeout with %0d results outstanding", rsp_expected.size());
        $display("FAIL");
        $finish;
    end

endmodule
